// ===== hw/rtl/srfp_pkg.sv =====
// ----------------------------------------------------------------------------
// srfp_pkg
// Types, request and status codes and the CRC-16 byte update shared by the
// sensor response frame parser.
// ----------------------------------------------------------------------------
package srfp_pkg;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_BYTE  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam logic [1:0] ST_ACK_OK  = 2'd0;
  localparam logic [1:0] ST_DATA_OK = 2'd1;
  localparam logic [1:0] ST_CRC_BAD = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [31:0] HDR_ACK  = 32'hFE4181E0;
  localparam logic [31:0] HDR_DATA = 32'hFE442C00;

  localparam logic [5:0] HDR_LEN     = 6'd4;
  localparam logic [5:0] IDX_CRC_LO  = 6'd47;
  localparam logic [5:0] IDX_STG0_LO = 6'd27;
  localparam logic [5:0] IDX_STG0_HI = 6'd30;
  localparam logic [5:0] IDX_STG1_LO = 6'd35;
  localparam logic [5:0] IDX_STG1_HI = 6'd38;
  localparam logic [5:0] IDX_STG2_LO = 6'd39;
  localparam logic [5:0] IDX_STG2_HI = 6'd42;

  localparam logic [15:0] TIMEOUT_RST = 16'd10000;
  localparam logic [15:0] TICK_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] rx_byte;
  } srfp_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] pressure_tenths;
    logic [15:0] co2_ppm;
    logic [15:0] vcap_first_mv;
    logic [15:0] vcap_second_mv;
    logic [31:0] error_word;
  } srfp_res_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  localparam logic [15:0] ACK_CRC  = crc_feed(crc_feed(CRC_INIT, 8'hFE), 8'h41);
  localparam logic [1:0]  ACK_STATUS = (ACK_CRC == {HDR_ACK[7:0], HDR_ACK[15:8]}) ?
                                       ST_ACK_OK : ST_CRC_BAD;
  localparam logic [15:0] DATA_HDR_CRC =
    crc_feed(crc_feed(crc_feed(crc_feed(CRC_INIT, 8'hFE), 8'h44), 8'h2C), 8'h00);

endpackage

// ===== hw/rtl/srfp_in_reg.sv =====
// ----------------------------------------------------------------------------
// srfp_in_reg
// Input register: holds one request until the core consumes it.
// ----------------------------------------------------------------------------
module srfp_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  srfp_pkg::srfp_item_t in_item,
  input  logic              fire,
  output logic              item_valid,
  output srfp_pkg::srfp_item_t item
);
  import srfp_pkg::*;

  logic       valid_r;
  srfp_item_t item_r;

  assign in_ready   = !valid_r || fire;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (fire) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== hw/rtl/srfp_core.sv =====
// ----------------------------------------------------------------------------
// srfp_core
// Exchange state: header hunt, frame body collection, CRC check, timeout and
// held measurements. Updates on each consumed request.
// ----------------------------------------------------------------------------
module srfp_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_timeout_ms,
  input  logic                 fire,
  input  srfp_pkg::srfp_item_t item,
  output logic                 res_valid,
  output srfp_pkg::srfp_res_t  res
);
  import srfp_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HUNT = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  logic [15:0] timeout_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] window_r, window_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [31:0] stg0_r, stg0_nxt;
  logic [31:0] stg1_r, stg1_nxt;
  logic [31:0] stg2_r, stg2_nxt;
  logic [15:0] pres_r, pres_nxt;
  logic [15:0] co2_r, co2_nxt;
  logic [31:0] vcap_r, vcap_nxt;
  logic [31:0] err_r, err_nxt;
  logic [31:0] shifted;
  logic [15:0] tick_inc;
  logic [1:0]  status;

  assign shifted  = {window_r[23:0], item.rx_byte};
  assign tick_inc = (tick_r != TICK_MAX) ? tick_r + 16'd1 : tick_r;

  always_comb begin
    phase_nxt  = phase_r;
    window_nxt = window_r;
    idx_nxt    = idx_r;
    crc_nxt    = crc_r;
    tick_nxt   = tick_r;
    crc_lo_nxt = crc_lo_r;
    stg0_nxt   = stg0_r;
    stg1_nxt   = stg1_r;
    stg2_nxt   = stg2_r;
    pres_nxt   = pres_r;
    co2_nxt    = co2_r;
    vcap_nxt   = vcap_r;
    err_nxt    = err_r;
    res_valid  = 1'b0;
    status     = ST_TIMEOUT;
    priority if (item.req_type == REQ_START) begin
      phase_nxt  = PH_HUNT;
      window_nxt = '0;
      idx_nxt    = '0;
      crc_nxt    = CRC_INIT;
      tick_nxt   = '0;
      crc_lo_nxt = '0;
    end else if (phase_r == PH_IDLE) begin
      phase_nxt = phase_r;
    end else if (item.req_type == REQ_TICK) begin
      tick_nxt = tick_inc;
      if (tick_inc >= timeout_r) begin
        res_valid = 1'b1;
        status    = ST_TIMEOUT;
        phase_nxt = PH_IDLE;
      end
    end else if (item.req_type == REQ_BYTE) begin
      if (phase_r == PH_HUNT) begin
        window_nxt = shifted;
        if (shifted == HDR_ACK) begin
          res_valid = 1'b1;
          status    = ACK_STATUS;
          phase_nxt = PH_IDLE;
        end else if (shifted == HDR_DATA) begin
          crc_nxt   = DATA_HDR_CRC;
          idx_nxt   = HDR_LEN;
          tick_nxt  = '0;
          phase_nxt = PH_BODY;
        end
      end else if (idx_r < IDX_CRC_LO) begin
        crc_nxt = crc_feed(crc_r, item.rx_byte);
        if (idx_r >= IDX_STG0_LO && idx_r <= IDX_STG0_HI) begin
          stg0_nxt = {stg0_r[23:0], item.rx_byte};
        end else if (idx_r >= IDX_STG1_LO && idx_r <= IDX_STG1_HI) begin
          stg1_nxt = {stg1_r[23:0], item.rx_byte};
        end else if (idx_r >= IDX_STG2_LO && idx_r <= IDX_STG2_HI) begin
          stg2_nxt = {stg2_r[23:0], item.rx_byte};
        end
        idx_nxt = idx_r + 6'd1;
      end else if (idx_r == IDX_CRC_LO) begin
        crc_lo_nxt = item.rx_byte;
        idx_nxt    = idx_r + 6'd1;
      end else begin
        res_valid = 1'b1;
        phase_nxt = PH_IDLE;
        if (crc_r == {item.rx_byte, crc_lo_r}) begin
          status   = ST_DATA_OK;
          pres_nxt = stg0_r[31:16];
          co2_nxt  = stg0_r[15:0];
          vcap_nxt = stg1_r;
          err_nxt  = stg2_r;
        end else begin
          status = ST_CRC_BAD;
        end
      end
    end
  end

  always_comb begin
    res.status          = status;
    res.pressure_tenths = pres_nxt;
    res.co2_ppm         = co2_nxt;
    res.vcap_first_mv   = vcap_nxt[31:16];
    res.vcap_second_mv  = vcap_nxt[15:0];
    res.error_word      = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      timeout_r <= cfg_timeout_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      window_r <= '0;
      idx_r    <= '0;
      crc_r    <= CRC_INIT;
      tick_r   <= '0;
      crc_lo_r <= '0;
      stg0_r   <= '0;
      stg1_r   <= '0;
      stg2_r   <= '0;
      pres_r   <= '0;
      co2_r    <= '0;
      vcap_r   <= '0;
      err_r    <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      window_r <= window_nxt;
      idx_r    <= idx_nxt;
      crc_r    <= crc_nxt;
      tick_r   <= tick_nxt;
      crc_lo_r <= crc_lo_nxt;
      stg0_r   <= stg0_nxt;
      stg1_r   <= stg1_nxt;
      stg2_r   <= stg2_nxt;
      pres_r   <= pres_nxt;
      co2_r    <= co2_nxt;
      vcap_r   <= vcap_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

// ===== hw/rtl/srfp_out_reg.sv =====
// ----------------------------------------------------------------------------
// srfp_out_reg
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module srfp_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic                res_valid,
  input  srfp_pkg::srfp_res_t res,
  input  logic                out_ready,
  output logic                out_valid,
  output srfp_pkg::srfp_res_t res_q
);
  import srfp_pkg::*;

  logic      valid_r;
  srfp_res_t res_r;

  assign out_valid = valid_r;
  assign res_q     = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (fire) begin
      valid_r <= res_valid;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// ===== hw/rtl/sensor_response_frame_parser.sv =====
// ----------------------------------------------------------------------------
// sensor_response_frame_parser
// Hunts sensor response headers, checks the Modbus CRC-16 of acknowledge and
// data frames, holds the last good measurements and reports timeouts.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid/in_ready, in_req_type, in_rx_byte | sink
//   out     | out_valid/out_ready, out_status, ...    | source
//   cfg     | cfg_valid/cfg_ready, cfg_timeout_ms     | sink
//
// One request accepted per cycle while the result register is not stalled; an
// accepted request is held in the input register, the core works on it and the
// result register loads its result when the request is consumed.
// Reset restores timeout_ms to 10000 and clears all exchange state.
// A stalled result holds the core; the input register takes one more request.
// ----------------------------------------------------------------------------
module sensor_response_frame_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [15:0] out_pressure_tenths,
  output logic [15:0]        out_co2_ppm,
  output logic [15:0]        out_vcap_first_mv,
  output logic [15:0]        out_vcap_second_mv,
  output logic [31:0]        out_error_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_timeout_ms
);
  import srfp_pkg::*;

  srfp_item_t in_item;
  srfp_item_t item;
  srfp_res_t  res;
  srfp_res_t  res_q;
  logic       item_valid;
  logic       fire;
  logic       res_valid;

  assign in_item.req_type = in_req_type;
  assign in_item.rx_byte  = in_rx_byte;
  assign cfg_ready        = 1'b1;
  assign fire             = item_valid && (!out_valid || out_ready);

  srfp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .fire       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  srfp_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_timeout_ms (cfg_timeout_ms),
    .fire           (fire),
    .item           (item),
    .res_valid      (res_valid),
    .res            (res)
  );

  srfp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_q     (res_q)
  );

  assign out_status          = res_q.status;
  assign out_pressure_tenths = res_q.pressure_tenths;
  assign out_co2_ppm         = res_q.co2_ppm;
  assign out_vcap_first_mv   = res_q.vcap_first_mv;
  assign out_vcap_second_mv  = res_q.vcap_second_mv;
  assign out_error_word      = res_q.error_word;

  a_result_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(fire && res_valid))
    else $error("result appeared without a consumed request");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> item_valid)
    else $error("accepted request not held in input register");

  a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && !fire |=> item_valid && $stable(item))
    else $error("blocked request lost or changed");

  a_no_fire_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !fire)
    else $error("core advanced while result stalled");

endmodule

// ===== tb/sensor_response_frame_parser_tb.sv =====
// ----------------------------------------------------------------------------
// sensor_response_frame_parser_tb
// Self-checking bench for the sensor response frame parser. A queue of
// requests (starts, received bytes, millisecond ticks and unused codes) feeds
// a valid/ready driver. Every accepted request steps a cycle-free model of
// the header hunt, CRC-16 check, timeout count and held measurements. Each
// result it predicts is compared field by field with what the block returns.
// Directed frames cover header overlap, restarts, CRC failures, field
// extremes and timeouts. Random exchanges follow under several timeout
// settings and three idling patterns, with a long receiver hold-off.
// ----------------------------------------------------------------------------
module sensor_response_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srfp_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam logic [15:0] ACK_CRC_SENT = 16'hE081;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 6;
  localparam int LONG_HOLD = 500;

  typedef enum logic [1:0] {EX_IDLE, EX_HUNT, EX_BODY} exchange_phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_req_type = 2'd0;
  logic [7:0] in_rx_byte = 8'd0;

  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic signed [15:0] out_pressure_tenths;
  logic [15:0] out_co2_ppm;
  logic [15:0] out_vcap_first_mv;
  logic [15:0] out_vcap_second_mv;
  logic [31:0] out_error_word;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_timeout_ms = 16'd0;

  srfp_item_t pending_reqs[$];
  srfp_res_t awaited_results[$];
  logic [7:0] frame_buf [0:48];

  int send_gap_pct = 27;
  int recv_stall_pct = 49;
  int items_queued = 0;
  int results_seen = 0;
  int fault_count = 0;
  int hold_left = 0;
  int unsigned cycle_count = 0;

  // parser model state
  logic [15:0] timeout_cfg = TIMEOUT_RST;
  exchange_phase_t ex_phase = EX_IDLE;
  logic [31:0] sync_win = '0;
  logic [5:0] byte_idx = '0;
  logic [15:0] crc_acc = CRC_INIT;
  logic [15:0] tick_cnt = '0;
  logic [7:0] crc_lo = '0;
  logic [31:0] stage_meas = '0;
  logic [31:0] stage_vcap = '0;
  logic [31:0] stage_err = '0;
  logic [15:0] held_pressure = '0;
  logic [15:0] held_co2 = '0;
  logic [31:0] held_vcaps = '0;
  logic [31:0] held_errors = '0;

  sensor_response_frame_parser uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_pressure_tenths (out_pressure_tenths),
    .out_co2_ppm         (out_co2_ppm),
    .out_vcap_first_mv   (out_vcap_first_mv),
    .out_vcap_second_mv  (out_vcap_second_mv),
    .out_error_word      (out_error_word),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_timeout_ms      (cfg_timeout_ms)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    r = acc ^ {8'h00, d};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  task automatic advance_parser(input logic [1:0] req, input logic [7:0] b);
    logic [15:0] c;
    logic done;
    logic [1:0] st;
    srfp_res_t r;
    done = 1'b0;
    st = ST_TIMEOUT;
    if (req == REQ_START) begin
      ex_phase = EX_HUNT;
      sync_win = '0;
      byte_idx = '0;
      crc_acc = CRC_INIT;
      tick_cnt = '0;
      crc_lo = '0;
    end else if (ex_phase != EX_IDLE && req != REQ_NONE) begin
      if (req == REQ_TICK) begin
        if (tick_cnt != TICK_MAX) tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= timeout_cfg) begin
          done = 1'b1;
          st = ST_TIMEOUT;
        end
      end else if (ex_phase == EX_HUNT) begin
        sync_win = {sync_win[23:0], b};
        if (sync_win == HDR_ACK) begin
          c = crc16_byte(crc16_byte(CRC_INIT, HDR_ACK[31:24]), HDR_ACK[23:16]);
          done = 1'b1;
          st = (c == ACK_CRC_SENT) ? ST_ACK_OK : ST_CRC_BAD;
        end else if (sync_win == HDR_DATA) begin
          c = CRC_INIT;
          for (int i = 3; i >= 0; i--) c = crc16_byte(c, sync_win[8*i +: 8]);
          crc_acc = c;
          byte_idx = HDR_LEN;
          tick_cnt = '0;
          ex_phase = EX_BODY;
        end
      end else begin
        if (byte_idx < IDX_CRC_LO) begin
          crc_acc = crc16_byte(crc_acc, b);
          if (byte_idx >= IDX_STG0_LO && byte_idx <= IDX_STG0_HI) begin
            stage_meas = {stage_meas[23:0], b};
          end else if (byte_idx >= IDX_STG1_LO && byte_idx <= IDX_STG1_HI) begin
            stage_vcap = {stage_vcap[23:0], b};
          end else if (byte_idx >= IDX_STG2_LO && byte_idx <= IDX_STG2_HI) begin
            stage_err = {stage_err[23:0], b};
          end
          byte_idx = byte_idx + 6'd1;
        end else if (byte_idx == IDX_CRC_LO) begin
          crc_lo = b;
          byte_idx = byte_idx + 6'd1;
        end else begin
          done = 1'b1;
          if (crc_acc == {b, crc_lo}) begin
            held_pressure = stage_meas[31:16];
            held_co2 = stage_meas[15:0];
            held_vcaps = stage_vcap;
            held_errors = stage_err;
            st = ST_DATA_OK;
          end else begin
            st = ST_CRC_BAD;
          end
        end
      end
    end
    if (done) begin
      ex_phase = EX_IDLE;
      r.status = st;
      r.pressure_tenths = held_pressure;
      r.co2_ppm = held_co2;
      r.vcap_first_mv = held_vcaps[31:16];
      r.vcap_second_mv = held_vcaps[15:0];
      r.error_word = held_errors;
      awaited_results.push_back(r);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    srfp_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) advance_parser(in_req_type, in_rx_byte);
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          nxt = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_req_type <= nxt.req_type;
          in_rx_byte <= nxt.rx_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    srfp_res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $error("unexpected result: status %0d with no result awaited", out_status);
          fault_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_status);
            fault_count++;
          end
          if (out_pressure_tenths !== want.pressure_tenths) begin
            $error("pressure_tenths mismatch: expected %0d, got %0d",
                   $signed(want.pressure_tenths), out_pressure_tenths);
            fault_count++;
          end
          if (out_co2_ppm !== want.co2_ppm) begin
            $error("co2_ppm mismatch: expected %h, got %h", want.co2_ppm, out_co2_ppm);
            fault_count++;
          end
          if (out_vcap_first_mv !== want.vcap_first_mv) begin
            $error("vcap_first_mv mismatch: expected %h, got %h",
                   want.vcap_first_mv, out_vcap_first_mv);
            fault_count++;
          end
          if (out_vcap_second_mv !== want.vcap_second_mv) begin
            $error("vcap_second_mv mismatch: expected %h, got %h",
                   want.vcap_second_mv, out_vcap_second_mv);
            fault_count++;
          end
          if (out_error_word !== want.error_word) begin
            $error("error_word mismatch: expected %h, got %h", want.error_word, out_error_word);
            fault_count++;
          end
        end
        // hold off for a long stretch so the block backs up
        if (results_seen % 40 == 20) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_req(input logic [1:0] req, input logic [7:0] b);
    srfp_item_t it;
    it.req_type = req;
    it.rx_byte = b;
    pending_reqs.push_back(it);
    items_queued++;
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) push_req(REQ_BYTE, w[8*i +: 8]);
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_req(REQ_TICK, 8'($urandom_range(255)));
  endtask

  task automatic push_noise_bytes(input int n);
    repeat (n) push_req(REQ_BYTE, 8'($urandom_range(255)));
  endtask

  function automatic int tick_room(input int cap);
    if (timeout_cfg == 16'd0) return 0;
    return (int'(timeout_cfg) - 1 < cap) ? int'(timeout_cfg) - 1 : cap;
  endfunction

  task automatic queue_hunt_lead(input int noise, input int ticks);
    while (noise + ticks > 0) begin
      if (ticks > 0 && (noise == 0 || $urandom_range(1) == 1)) begin
        push_ticks(1);
        ticks--;
      end else begin
        push_noise_bytes(1);
        noise--;
      end
    end
  endtask

  task automatic fill_frame();
    for (int i = 0; i < 4; i++) frame_buf[i] = HDR_DATA[31 - 8*i -: 8];
    for (int i = 4; i < 49; i++) frame_buf[i] = 8'($urandom_range(255));
  endtask

  task automatic set_frame_fields(input logic [15:0] p, input logic [15:0] co2,
                                  input logic [15:0] v1, input logic [15:0] v2,
                                  input logic [31:0] err);
    logic [31:0] meas_w;
    logic [31:0] vcap_w;
    meas_w = {p, co2};
    vcap_w = {v1, v2};
    for (int i = 0; i < 4; i++) begin
      frame_buf[27 + i] = meas_w[31 - 8*i -: 8];
      frame_buf[35 + i] = vcap_w[31 - 8*i -: 8];
      frame_buf[39 + i] = err[31 - 8*i -: 8];
    end
  endtask

  task automatic queue_frame(input logic corrupt, input int body_ticks);
    logic [15:0] c;
    c = CRC_INIT;
    for (int i = 0; i < 47; i++) c = crc16_byte(c, frame_buf[i]);
    frame_buf[47] = c[7:0];
    frame_buf[48] = c[15:8];
    if (corrupt) frame_buf[47 + $urandom_range(1)] ^= 8'($urandom_range(1, 255));
    for (int i = 0; i < 49; i++) begin
      if (i >= 4) begin
        while (body_ticks > 0 && (i == 48 || $urandom_range(7) == 0)) begin
          push_ticks(1);
          body_ticks--;
        end
        if ($urandom_range(39) == 0) push_req(REQ_NONE, 8'($urandom_range(255)));
      end
      push_req(REQ_BYTE, frame_buf[i]);
    end
  endtask

  task automatic queue_random_exchange();
    int pick;
    pick = $urandom_range(99);
    if (pick >= 86) begin
      repeat ($urandom_range(1, 6)) push_req(2'($urandom_range(3)), 8'($urandom_range(255)));
      return;
    end
    push_req(REQ_START, 8'($urandom_range(255)));
    if (pick < 40) begin
      queue_hunt_lead($urandom_range(3), tick_room($urandom_range(3)));
      fill_frame();
      queue_frame($urandom_range(4) == 0, tick_room($urandom_range(6)));
    end else if (pick < 62) begin
      queue_hunt_lead($urandom_range(3), tick_room($urandom_range(3)));
      push_word(HDR_ACK);
    end else if (pick < 74 && timeout_cfg <= 16'd40) begin
      if ($urandom_range(1) == 1) begin
        push_word(HDR_DATA);
        push_noise_bytes($urandom_range(40));
      end else begin
        queue_hunt_lead($urandom_range(5), 0);
      end
      push_ticks((timeout_cfg == 16'd0) ? 1 : int'(timeout_cfg));
    end else begin
      // abandoned exchanges: the next start restarts them
      case ($urandom_range(2))
        0: push_word({HDR_DATA[31:8], 8'($urandom_range(1, 255))});
        1: push_word({HDR_ACK[31:8], 8'($urandom_range(255))});
        default: begin
          push_word(HDR_DATA);
          push_noise_bytes($urandom_range(1, 44));
        end
      endcase
    end
  endtask

  task automatic queue_random_traffic(input int n);
    int stop_at;
    stop_at = items_queued + n;
    while (items_queued < stop_at) queue_random_exchange();
  endtask

  function automatic logic exchange_busy();
    return pending_reqs.size() != 0 || in_valid || awaited_results.size() != 0;
  endfunction

  task automatic wait_quiet();
    logic settled;
    settled = 1'b0;
    while (!settled) begin
      do @(posedge clk); while (exchange_busy());
      repeat (DRAIN_CYCLES) @(posedge clk);
      settled = !exchange_busy();
    end
  endtask

  task automatic write_timeout(input logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_timeout_ms <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    timeout_cfg = v;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    write_timeout(16'd12);
    // ignored while idle, and the unused code
    push_req(REQ_TICK, 8'h00);
    push_req(REQ_BYTE, 8'hFF);
    push_req(REQ_NONE, 8'hA5);
    push_req(REQ_START, 8'h00);
    push_word(HDR_ACK);
    // start clears the window; overlapping header still found
    push_req(REQ_START, 8'hFF);
    push_word({8'h00, HDR_ACK[31:8]});
    push_req(REQ_START, 8'h00);
    push_req(REQ_BYTE, HDR_ACK[7:0]);
    push_req(REQ_BYTE, HDR_ACK[31:24]);
    push_word(HDR_ACK);
    push_req(REQ_START, 8'h00);
    fill_frame();
    set_frame_fields(16'h8000, 16'hFFFF, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
    queue_frame(1'b0, 0);
    push_req(REQ_START, 8'h00);
    fill_frame();
    set_frame_fields(16'h7FFF, 16'h0000, 16'hFFFF, 16'h0000, 32'h0000_0000);
    queue_frame(1'b1, 0);
    push_req(REQ_START, 8'h00);
    fill_frame();
    set_frame_fields(16'h7FFF, 16'h0000, 16'hFFFF, 16'h0000, 32'h0000_0000);
    push_ticks(11);
    queue_frame(1'b0, 11);
    push_req(REQ_START, 8'h00);
    push_ticks(12);
    push_req(REQ_START, 8'h00);
    push_word(HDR_DATA);
    push_noise_bytes(5);
    push_ticks(12);
    // leave an exchange open across the next register write
    push_req(REQ_START, 8'h00);
    push_ticks(10);
    wait_quiet();

    write_timeout(16'd4);
    push_ticks(1);
    queue_random_traffic(140);
    wait_quiet();

    write_timeout(16'd0);
    push_req(REQ_START, 8'h00);
    push_req(REQ_BYTE, HDR_ACK[31:24]);
    push_req(REQ_BYTE, HDR_ACK[23:16]);
    push_ticks(1);
    queue_random_traffic(140);
    wait_quiet();

    send_gap_pct = 49;
    recv_stall_pct = 27;
    write_timeout(16'hFFFF);
    queue_random_traffic(150);
    wait_quiet();

    write_timeout(16'd1);
    queue_random_traffic(140);
    wait_quiet();

    send_gap_pct = 0;
    recv_stall_pct = 0;
    write_timeout(16'd30);
    queue_random_traffic(150);
    wait_quiet();

    write_timeout(16'd300);
    queue_random_traffic(150);
    wait_quiet();

    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
